@@ design/b64d_pkg.sv @@
// shared types, constants and the alphabet lookup for the base64 decoder
package b64d_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_INVALID = 2'd1;
   localparam logic [1:0] STATUS_LENGTH = 2'd2;

   localparam logic [7:0] CHAR_PAD = 8'h3D;
   localparam logic [7:0] CHAR_NUL = 8'h00;
   localparam logic [7:0] CHAR_PLUS = 8'h2B;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   localparam logic [2:0] NO_PAD = 3'd4;

   typedef struct packed {
      logic [7:0] char_code;
      logic       final_char;
   } req_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_data;
      logic       end_of_string;
      logic [1:0] status;
   } rsp_type;

   // one decoded quantum or end marker, expanded to results by the back end
   typedef struct packed {
      logic [23:0] word;
      logic [1:0]  count;
      logic        has_data;
      logic        end_of_string;
      logic [1:0]  status;
   } desc_type;

   // bit 6 set when the character is in the alphabet, bits 5:0 the sextet
   function automatic logic [6:0] sextet_of(input logic [7:0] c);
      logic [6:0] r;
      r = 7'd0;
      case (c) inside
         [8'h41:8'h5A]: r = {1'b1, 6'(c - 8'h41)};
         [8'h61:8'h7A]: r = {1'b1, 6'(c - 8'h61 + 8'd26)};
         [8'h30:8'h39]: r = {1'b1, 6'(c - 8'h30 + 8'd52)};
         CHAR_PLUS:     r = {1'b1, 6'd62};
         CHAR_SLASH:    r = {1'b1, 6'd63};
         default:       r = 7'd0;
      endcase
      return r;
   endfunction

endpackage

@@ design/b64d_front.sv @@
// front end: classifies characters, gathers quanta and emits descriptors
module b64d_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  b64d_pkg::req_type req_data,
   output logic              desc_push,
   input  logic              desc_full,
   output b64d_pkg::desc_type desc_data
);
   import b64d_pkg::*;

   logic [1:0]  qpos_ff, qpos_in;
   logic [17:0] store_ff, store_in;
   logic [2:0]  pad_ff, pad_in;
   logic        err_ff, err_in;

   logic        accept;
   logic        is_pad;
   logic [6:0]  lookup;
   logic [5:0]  sextet;
   logic [2:0]  pad_now;
   logic        err_now;
   logic [23:0] word;
   logic        complete;
   logic [1:0]  keep;

   assign req_full = desc_full;
   assign accept = req_push && !desc_full;

   always_comb begin
      is_pad = (req_data.char_code == CHAR_PAD) || (req_data.char_code == CHAR_NUL);
      lookup = sextet_of(req_data.char_code);
      sextet = (lookup[6] && !is_pad) ? lookup[5:0] : 6'd0;
      pad_now = (is_pad && pad_ff == NO_PAD) ? {1'b0, qpos_ff} : pad_ff;
      err_now = err_ff || (!is_pad && !lookup[6]);
      word = {store_ff, sextet};
      complete = (qpos_ff == 2'd3);
      // bytes kept in the final quantum given the first pad position
      if (pad_now[2]) begin
         keep = 2'd3;
      end else if (!pad_now[1]) begin
         keep = 2'd0;
      end else begin
         keep = pad_now[1:0] - 2'd1;
      end

      qpos_in = qpos_ff;
      store_in = store_ff;
      pad_in = pad_ff;
      err_in = err_ff;
      desc_push = 1'b0;
      desc_data.word = word;
      desc_data.count = 2'd3;
      desc_data.has_data = 1'b1;
      desc_data.end_of_string = 1'b0;
      desc_data.status = STATUS_OK;

      if (accept) begin
         if (req_data.final_char) begin
            desc_push = 1'b1;
            desc_data.end_of_string = 1'b1;
            if (!complete || err_now) begin
               desc_data.count = 2'd1;
               desc_data.has_data = 1'b0;
               desc_data.status = complete ? STATUS_INVALID : STATUS_LENGTH;
            end else if (keep == 2'd0) begin
               desc_data.count = 2'd1;
               desc_data.has_data = 1'b0;
            end else begin
               desc_data.count = keep;
            end
            qpos_in = 2'd0;
            store_in = 18'd0;
            pad_in = NO_PAD;
            err_in = 1'b0;
         end else if (complete) begin
            // a pad inside a non-final quantum is an error
            err_in = err_now || (pad_now != NO_PAD);
            desc_push = !(err_now || (pad_now != NO_PAD));
            qpos_in = 2'd0;
            store_in = 18'd0;
            pad_in = NO_PAD;
         end else begin
            err_in = err_now;
            pad_in = pad_now;
            store_in = word[17:0];
            qpos_in = qpos_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qpos_ff <= 2'd0;
         store_ff <= 18'd0;
         pad_ff <= NO_PAD;
         err_ff <= 1'b0;
      end else begin
         qpos_ff <= qpos_in;
         store_ff <= store_in;
         pad_ff <= pad_in;
         err_ff <= err_in;
      end
   end

endmodule

@@ design/b64d_queue.sv @@
// short descriptor queue between the front and back ends
module b64d_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  b64d_pkg::desc_type push_data,
   input  logic               pop,
   output logic               empty,
   output b64d_pkg::desc_type head
);
   import b64d_pkg::*;

   desc_type mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ff, wr_in;
   logic [QUEUE_AW-1:0] rd_ff, rd_in;
   logic [QUEUE_CW-1:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign full = (cnt_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head = mem_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   always_comb begin
      wr_in = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

@@ design/b64d_back.sv @@
// back end: expands descriptors into result transactions through an output register
module b64d_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               desc_empty,
   output logic               desc_pop,
   input  b64d_pkg::desc_type desc_head,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output b64d_pkg::rsp_type  rsp_data
);
   import b64d_pkg::*;

   desc_type   cur_ff, cur_in;
   logic       cur_valid_ff, cur_valid_in;
   logic [1:0] idx_ff, idx_in;
   rsp_type    out_ff, out_in;
   logic       out_valid_ff, out_valid_in;

   logic       advance;
   logic       last;
   logic [7:0] byte_sel;

   assign rsp_empty = !out_valid_ff;
   assign rsp_data = out_ff;

   always_comb begin
      advance = !out_valid_ff || rsp_pop;
      last = (idx_ff == cur_ff.count - 2'd1);
      case (idx_ff)
         2'd0:    byte_sel = cur_ff.word[23:16];
         2'd1:    byte_sel = cur_ff.word[15:8];
         2'd2:    byte_sel = cur_ff.word[7:0];
         default: byte_sel = 8'd0;
      endcase

      out_in = out_ff;
      out_valid_in = out_valid_ff;
      idx_in = idx_ff;
      cur_valid_in = cur_valid_ff;
      cur_in = cur_ff;

      if (advance) begin
         out_valid_in = cur_valid_ff;
         if (cur_valid_ff) begin
            out_in.data_byte = cur_ff.has_data ? byte_sel : 8'd0;
            out_in.has_data = cur_ff.has_data;
            out_in.end_of_string = cur_ff.end_of_string && last;
            out_in.status = last ? cur_ff.status : STATUS_OK;
            idx_in = idx_ff + 2'd1;
            if (last) begin
               cur_valid_in = 1'b0;
            end
         end
      end

      // refill the current descriptor as soon as the last result leaves it
      desc_pop = !desc_empty && (!cur_valid_ff || (advance && last));
      if (desc_pop) begin
         cur_in = desc_head;
         cur_valid_in = 1'b1;
         idx_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      out_ff <= out_in;
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

@@ design/base64_decoder.sv @@
// top level of the streaming base64 decoder
// Usage: characters enter as queue pushes on req_push/req_full, one per
// transaction, with final_char set on the last character of a string.
// Decoded bytes leave as a queue on rsp_empty/rsp_pop: the oldest result
// sits on rsp_data while rsp_empty is low and leaves when rsp_pop is high.
// Each complete quantum of four characters, with no pad or invalid character
// in the string so far, yields three byte results; the last character of a
// string yields an end_of_string result with its status (ok, invalid, length).
// Throughput: one character per cycle while req_full is low; results leave
// at up to one per cycle from one output register and a 4-entry descriptor
// queue, so 3 bytes per 4 characters never stall input while rsp_pop is high.
// Path: the first result of a quantum reaches rsp_data after the transaction
// that completes the quantum through the queue write, the descriptor load and
// the output register.
// Receiver stall: results wait in the output register and the descriptor
// queue; req_full rises once the queue holds four descriptors.
// Reset: synchronous, clears the gathered quantum, the sticky error and
// all queued results; the block is ready the cycle after reset falls.
module base64_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  b64d_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output b64d_pkg::rsp_type rsp_data
);
   import b64d_pkg::*;

   logic     desc_push;
   logic     desc_full;
   desc_type desc_in;
   logic     desc_pop;
   logic     desc_empty;
   desc_type desc_head;

   b64d_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .desc_push (desc_push),
      .desc_full (desc_full),
      .desc_data (desc_in)
   );

   b64d_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (desc_push),
      .full      (desc_full),
      .push_data (desc_in),
      .pop       (desc_pop),
      .empty     (desc_empty),
      .head      (desc_head)
   );

   b64d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .desc_empty (desc_empty),
      .desc_pop   (desc_pop),
      .desc_head  (desc_head),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("results present after reset");

   a_status_on_end: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.end_of_string) |-> (rsp_data.status == STATUS_OK))
      else $error("nonzero status on a result that does not end a string");

   a_error_no_data: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.status != STATUS_OK) |-> !rsp_data.has_data)
      else $error("error result carries a data byte");

   a_empty_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.has_data) |-> (rsp_data.data_byte == 8'd0))
      else $error("result without data has a nonzero byte");

endmodule

@@ tb/sv/base64_decoder_tb.sv @@
// testbench for the streaming base64 decoder: directed strings, random strings, scoreboard
module base64_decoder_tb;
   import b64d_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_CHARS = 60;
   localparam int BURST_CHARS = 40;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_NOISE = 8'hFF;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;

   // decoder state mirrored by the predictor
   logic [1:0]  quantum_pos = 2'd0;
   logic [17:0] sextet_acc = 18'd0;
   logic [2:0]  pad_index = NO_PAD;
   logic [1:0]  sticky_status = STATUS_OK;

   rsp_type pending_results[$];

   int  fail_count = 0;
   int  chars_sent = 0;
   int  strings_sent = 0;
   int  results_checked = 0;
   int  idle_cycles = 0;
   int  pop_hold = 0;
   bit  quiet_mode = 1'b0;

   always #5 clock = ~clock;

   base64_decoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // mostly no gap, some short ones, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_mode || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [7:0] random_alphabet_char();
      int idx;
      idx = $urandom_range(0, 63);
      if (idx < 26) return CHAR_UPPER_A + 8'(idx);
      if (idx < 52) return CHAR_LOWER_A + 8'(idx - 26);
      if (idx < 62) return CHAR_DIGIT_0 + 8'(idx - 52);
      if (idx == 62) return CHAR_PLUS;
      return CHAR_SLASH;
   endfunction

   function automatic void lookup_sextet(input logic [7:0] c, output logic ok,
                                         output logic [5:0] v);
      ok = 1'b1;
      v = 6'd0;
      if (c >= CHAR_UPPER_A && c < CHAR_UPPER_A + 8'd26) v = 6'(c - CHAR_UPPER_A);
      else if (c >= CHAR_LOWER_A && c < CHAR_LOWER_A + 8'd26) v = 6'(c - CHAR_LOWER_A + 8'd26);
      else if (c >= CHAR_DIGIT_0 && c < CHAR_DIGIT_0 + 8'd10) v = 6'(c - CHAR_DIGIT_0 + 8'd52);
      else if (c == CHAR_PLUS) v = 6'd62;
      else if (c == CHAR_SLASH) v = 6'd63;
      else ok = 1'b0;
   endfunction

   function automatic void queue_result(input logic [7:0] b, input logic has,
                                        input logic last, input logic [1:0] st);
      rsp_type r;
      r.data_byte = b;
      r.has_data = has;
      r.end_of_string = last;
      r.status = st;
      pending_results.push_back(r);
   endfunction

   // expected results of one accepted character
   function automatic void predict_decode(input logic [7:0] c, input logic fin);
      logic        complete;
      logic        ok;
      logic [5:0]  v;
      logic [23:0] word;
      logic [1:0]  st;
      int          keep;
      complete = (quantum_pos == 2'd3);
      v = 6'd0;
      if (c == CHAR_PAD || c == CHAR_NUL) begin
         if (pad_index == NO_PAD) pad_index = {1'b0, quantum_pos};
      end else begin
         lookup_sextet(c, ok, v);
         if (!ok) begin
            sticky_status = STATUS_INVALID;
            v = 6'd0;
         end
      end
      word = {sextet_acc, v};
      if (!complete) begin
         sextet_acc = word[17:0];
         quantum_pos = quantum_pos + 2'd1;
      end
      if (fin) begin
         st = complete ? sticky_status : STATUS_LENGTH;
         keep = 3;
         if (pad_index != NO_PAD) keep = (pad_index < 3'd2) ? 0 : int'(pad_index) - 1;
         if (st != STATUS_OK || keep == 0) begin
            queue_result(8'd0, 1'b0, 1'b1, st);
         end else begin
            for (int i = 0; i < keep; i++)
               queue_result(word[23 - 8 * i -: 8], 1'b1, i == keep - 1, STATUS_OK);
         end
         quantum_pos = 2'd0;
         sextet_acc = 18'd0;
         pad_index = NO_PAD;
         sticky_status = STATUS_OK;
      end else if (complete) begin
         // a pad anywhere but the last quantum poisons the string
         if (pad_index != NO_PAD) sticky_status = STATUS_INVALID;
         if (sticky_status == STATUS_OK) begin
            for (int i = 0; i < 3; i++)
               queue_result(word[23 - 8 * i -: 8], 1'b1, 1'b0, STATUS_OK);
         end
         quantum_pos = 2'd0;
         sextet_acc = 18'd0;
         pad_index = NO_PAD;
      end
   endfunction

   task automatic send_char(input logic [7:0] c, input logic fin);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= '{char_code: c, final_char: fin};
      do @(posedge clock); while (req_full);
      predict_decode(c, fin);
      chars_sent++;
      if (fin) strings_sent++;
   endtask

   task automatic send_text(input string s, input logic last_final);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i], last_final && (i == s.len() - 1));
   endtask

   // sender holds off until every expected result has been popped
   task automatic wait_for_drain();
      req_push <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic test_alphabet_edges();
      send_text("AZ09", 1'b0);
      send_text("+/az", 1'b1);
   endtask

   task automatic test_padding();
      send_text("TQ==", 1'b1);
      send_text("TWE", 1'b0);
      send_char(CHAR_NUL, 1'b1);
      // pad in position zero, then a valid character after the pad
      send_char(CHAR_NUL, 1'b0);
      send_text("A==", 1'b1);
   endtask

   task automatic test_errors();
      // misplaced pad then a length-breaking final character, then an invalid character
      send_text("TQ==", 1'b0);
      send_char(CHAR_NOISE, 1'b1);
      send_text("T", 1'b0);
      send_char(CHAR_NOISE, 1'b0);
      send_text("Fu", 1'b1);
   endtask

   task automatic send_random_string();
      int         kind;
      int         n_chars;
      int         pads;
      logic [7:0] c;
      kind = $urandom_range(0, 9);
      n_chars = 4 * $urandom_range(1, 3);
      pads = $urandom_range(0, 2);
      if (kind == 6) pads = $urandom_range(3, 4);
      if (kind >= 7) n_chars = $urandom_range(1, 13);
      for (int i = 0; i < n_chars; i++) begin
         c = random_alphabet_char();
         if (i >= n_chars - pads && !(kind == 5 && i > n_chars - pads && $urandom_range(0, 1)))
            c = $urandom_range(0, 1) ? CHAR_PAD : CHAR_NUL;
         if (kind >= 7 && $urandom_range(0, 4) == 0) c = 8'($urandom_range(0, 255));
         if (kind >= 8 && $urandom_range(0, 5) == 0) c = CHAR_PAD;
         send_char(c, i == n_chars - 1);
      end
   endtask

   task automatic test_random_strings();
      int target;
      int n;
      target = chars_sent + RANDOM_CHARS;
      n = 0;
      while (chars_sent < target) begin
         send_random_string();
         n++;
         if (n % 5 == 0) wait_for_drain();
      end
   endtask

   task automatic test_back_to_back();
      int target;
      target = chars_sent + BURST_CHARS;
      quiet_mode = 1'b1;
      while (chars_sent < target) send_random_string();
      quiet_mode = 1'b0;
   endtask

   // result checker and receiver stalls
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result transaction data_byte %0h end %0b status %0d",
                   rsp_data.data_byte, rsp_data.end_of_string, rsp_data.status);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (rsp_data.data_byte !== want.data_byte) begin
               $error("data_byte expected %0h actual %0h", want.data_byte, rsp_data.data_byte);
               fail_count++;
            end
            if (rsp_data.has_data !== want.has_data) begin
               $error("has_data expected %0b actual %0b", want.has_data, rsp_data.has_data);
               fail_count++;
            end
            if (rsp_data.end_of_string !== want.end_of_string) begin
               $error("end_of_string expected %0b actual %0b",
                      want.end_of_string, rsp_data.end_of_string);
               fail_count++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_data.status);
               fail_count++;
            end
         end
         pop_hold = pick_gap();
      end
      if (pop_hold != 0) begin
         pop_hold--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // watchdog on cycles with no transaction on either side
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_alphabet_edges();
      test_padding();
      test_errors();
      test_random_strings();
      test_back_to_back();
      wait_for_drain();
      repeat (8) @(posedge clock);
      $display("covered %0d strings, %0d characters, %0d results checked",
               strings_sent, chars_sent, results_checked);
      $display("padding, invalid characters, misplaced pads and bad lengths under random stalls");
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
